// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge while reset is released.
`define SLM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// Check a property on every clock edge, reset included.
`define SLM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- rtl/core/slm_pkg.sv -----
// ----------------------------------------------------------------------------
// Sound level meter package
// Shared constants, register indexes and class codes.
// ----------------------------------------------------------------------------
package slm_pkg;

    localparam int SAMPLE_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF  = 16;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CAL_OFFSET    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_WEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_QUIET_THRESH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LOUD_THRESH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HYST_MARGIN   = 3'd5;

    localparam logic [15:0] WINDOW_LENGTH_RST = 16'd6656;
    localparam logic [15:0] CAL_OFFSET_RST    = 16'd28390;
    localparam logic [15:0] SMOOTH_WEIGHT_RST = 16'd9830;
    localparam logic [14:0] QUIET_THRESH_RST  = 15'd11520;
    localparam logic [14:0] LOUD_THRESH_RST   = 15'd15360;
    localparam logic [11:0] HYST_MARGIN_RST   = 12'd512;

    // 10*log10(2) in Q.16
    localparam int LOG10_2_X10_Q16 = 197283;
    localparam int FS_LEVEL_MIN    = -24576;
    localparam int EST_MIN         = 7680;
    localparam int EST_MAX         = 30720;
    // 50 dB in Q8.16
    localparam logic [23:0] SMOOTH_RST = 24'd3276800;

    typedef enum logic [1:0] {
        CLS_QUIET  = 2'd0,
        CLS_NORMAL = 2'd1,
        CLS_LOUD   = 2'd2
    } level_class_t;

endpackage

// ----- rtl/core/slm_front.sv -----
// ----------------------------------------------------------------------------
// Sound level meter front end
// Squares each sample, accumulates the window and hands closed windows on.
// ----------------------------------------------------------------------------
module slm_front #(
    parameter int SAMPLE_BITS = slm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = slm_pkg::COUNT_BITS_DEF,
    parameter int SUM_W       = 2 * (SAMPLE_BITS - 1) + 1 + COUNT_BITS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    input  logic [15:0]                   window_length,
    input  logic                          fifo_full,
    output logic                          fifo_push,
    output logic [SUM_W-1:0]              push_sum,
    output logic [COUNT_BITS-1:0]         push_cnt
);

    localparam int CMP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [SUM_W-1:0]        sum_reg;
    logic [COUNT_BITS-1:0]   cnt_reg;
    logic [SAMPLE_BITS-1:0]  mag;
    logic [2*SAMPLE_BITS-1:0] sq;
    logic [SUM_W-1:0]        sum_new;
    logic [COUNT_BITS-1:0]   cnt_new;
    logic                    accept;
    logic                    close;

    assign s_ready = !fifo_full;
    assign accept  = s_valid && s_ready;

    // most negative sample maps to 2^(SAMPLE_BITS-1), still fits unsigned
    assign mag     = s_sample[SAMPLE_BITS-1] ? (~s_sample + 1'b1) : s_sample;
    assign sq      = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);
    assign sum_new = sum_reg + SUM_W'(sq);
    assign cnt_new = cnt_reg + 1'b1;
    assign close   = (CMP_W'(cnt_new) >= CMP_W'(window_length)) || (cnt_new == CNT_MAX);

    assign fifo_push = accept && close;
    assign push_sum  = sum_new;
    assign push_cnt  = cnt_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end else if (accept) begin
            if (close) begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_new;
                cnt_reg <= cnt_new;
            end
        end
    end

endmodule

// ----- rtl/core/slm_queue.sv -----
// ----------------------------------------------------------------------------
// Sound level meter window queue
// Two-entry queue of closed windows between front and back end.
// ----------------------------------------------------------------------------
module slm_queue #(
    parameter int DATA_W = 63
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic              full,
    output logic              not_empty,
    output logic [DATA_W-1:0] head_data
);

    logic [DATA_W-1:0] entry_reg [2];
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic [1:0]        fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head_data = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 2'd1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

// ----- rtl/core/slm_log2.sv -----
// ----------------------------------------------------------------------------
// Sound level meter log2 unit
// Iterative log2 in Q.16: one-bit normalize steps, then 16 squarings.
// ----------------------------------------------------------------------------
module slm_log2 #(
    parameter int X_W    = 47,
    parameter int NORM_W = (X_W > 32) ? X_W : 32,
    parameter int LOG_W  = $clog2(NORM_W) + 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [X_W-1:0]   x,
    output logic             done,
    output logic [LOG_W-1:0] result
);

    localparam int NB = LOG_W - 16;

    typedef enum logic [2:0] {
        L_IDLE = 3'b001,
        L_NORM = 3'b010,
        L_SQR  = 3'b100
    } log_state_t;

    log_state_t        state_reg;
    logic [NORM_W-1:0] t_reg;
    logic [NB-1:0]     n_reg;
    logic [31:0]       m_reg;
    logic [15:0]       frac_reg;
    logic [3:0]        iter_reg;
    logic              done_reg;
    logic [63:0]       m_sq;
    logic [32:0]       m_sh;

    assign m_sq   = 64'(m_reg) * 64'(m_reg);
    assign m_sh   = m_sq[63:31];
    assign done   = done_reg;
    assign result = {n_reg, frac_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        t_reg     <= NORM_W'(x);
                        n_reg     <= NB'(NORM_W - 1);
                        state_reg <= L_NORM;
                    end
                end
                L_NORM: begin
                    // stop at the leading one, or at bit 0 for a zero input
                    if (t_reg[NORM_W-1] || (n_reg == '0)) begin
                        m_reg     <= t_reg[NORM_W-1 -: 32];
                        frac_reg  <= '0;
                        iter_reg  <= '0;
                        state_reg <= L_SQR;
                    end else begin
                        t_reg <= {t_reg[NORM_W-2:0], 1'b0};
                        n_reg <= n_reg - 1'b1;
                    end
                end
                L_SQR: begin
                    if (m_sh[32]) begin
                        m_reg <= m_sh[32:1];
                    end else begin
                        m_reg <= m_sh[31:0];
                    end
                    frac_reg <= {frac_reg[14:0], m_sh[32]};
                    iter_reg <= iter_reg + 4'd1;
                    if (iter_reg == 4'd15) begin
                        done_reg  <= 1'b1;
                        state_reg <= L_IDLE;
                    end
                end
                default: state_reg <= L_IDLE;
            endcase
        end
    end

endmodule

// ----- rtl/core/slm_back.sv -----
// ----------------------------------------------------------------------------
// Sound level meter back end
// Per-window level math, smoothing, hysteresis and the result register.
// ----------------------------------------------------------------------------
module slm_back #(
    parameter int SAMPLE_BITS = slm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = slm_pkg::COUNT_BITS_DEF,
    parameter int SUM_W       = 2 * (SAMPLE_BITS - 1) + 1 + COUNT_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     fifo_not_empty,
    input  logic [SUM_W-1:0]         fifo_sum,
    input  logic [COUNT_BITS-1:0]    fifo_cnt,
    output logic                     fifo_pop,
    input  logic [15:0]              cal_offset,
    input  logic [15:0]              smooth_weight,
    input  logic [14:0]              quiet_thresh,
    input  logic [14:0]              loud_thresh,
    input  logic [11:0]              hyst_margin,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [15:0]       m_full_scale_level,
    output logic [14:0]              m_estimated_level,
    output logic [14:0]              m_smoothed_level_out,
    output logic [1:0]               m_level_class
);

    localparam int NORM_W = (SUM_W > 32) ? SUM_W : 32;
    localparam int LOG_W  = $clog2(NORM_W) + 16;
    localparam int D_W    = LOG_W + 2;
    localparam int P_W    = D_W + 19;
    localparam logic signed [D_W-1:0] BITS_OFFS = D_W'(2 * (SAMPLE_BITS - 1) * 65536);
    localparam logic signed [P_W-1:0] LOG_K     = P_W'(slm_pkg::LOG10_2_X10_Q16);
    localparam logic signed [P_W-1:0] RND_24    = P_W'(1 << 23);
    localparam logic signed [P_W-1:0] FS_MIN    = P_W'(slm_pkg::FS_LEVEL_MIN);
    localparam logic signed [P_W-1:0] FS_MAX    = P_W'(0);
    localparam logic signed [17:0]    EST_LO    = 18'(slm_pkg::EST_MIN);
    localparam logic signed [17:0]    EST_HI    = 18'(slm_pkg::EST_MAX);

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_LOG_SUM = 9'b000000010,
        ST_LOG_CNT = 9'b000000100,
        ST_SCALE   = 9'b000001000,
        ST_ROUND   = 9'b000010000,
        ST_EST     = 9'b000100000,
        ST_SMUL    = 9'b001000000,
        ST_SADD    = 9'b010000000,
        ST_CLASS   = 9'b100000000
    } back_state_t;

    back_state_t               state_reg;
    logic [COUNT_BITS-1:0]     cnt_reg;
    logic [LOG_W-1:0]          lsum_reg;
    logic signed [D_W-1:0]     d_reg;
    logic signed [P_W-1:0]     prod_reg;
    logic signed [15:0]        fs_reg;
    logic [14:0]               est_reg;
    logic signed [43:0]        sprod_reg;
    logic [23:0]               s_reg;
    slm_pkg::level_class_t     cls_reg;
    logic                      m_valid_reg;
    logic signed [15:0]        m_fs_reg;
    logic [14:0]               m_est_reg;
    logic [14:0]               m_sm_reg;
    logic [1:0]                m_cls_reg;

    logic                      log_start;
    logic [SUM_W-1:0]          log_x;
    logic                      log_done;
    logic [LOG_W-1:0]          log_res;
    logic                      silent;
    logic signed [D_W-1:0]     d_next;
    logic signed [P_W-1:0]     rnd;
    logic signed [15:0]        fs_next;
    logic signed [17:0]        est_sum;
    logic [14:0]               est_next;
    logic signed [26:0]        sdiff;
    logic signed [43:0]        srnd;
    logic [24:0]               s_rnd;
    logic [16:0]               s_q88;
    logic [14:0]               sm;
    logic signed [17:0]        lvl;
    logic signed [17:0]        q_s;
    logic signed [17:0]        l_s;
    logic signed [17:0]        mg_s;
    slm_pkg::level_class_t     cls_next;
    logic                      out_free;

    slm_log2 #(
        .X_W    (SUM_W),
        .NORM_W (NORM_W),
        .LOG_W  (LOG_W)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (log_x),
        .done    (log_done),
        .result  (log_res)
    );

    assign silent    = fifo_sum < SUM_W'(fifo_cnt);
    assign fifo_pop  = (state_reg == ST_IDLE) && fifo_not_empty;
    assign log_start = (fifo_pop && !silent) || ((state_reg == ST_LOG_SUM) && log_done);
    assign log_x     = (state_reg == ST_IDLE) ? fifo_sum : SUM_W'(cnt_reg);

    assign d_next = $signed({2'b00, lsum_reg}) - $signed({2'b00, log_res}) - BITS_OFFS;
    assign rnd    = (prod_reg + RND_24) >>> 24;

    always_comb begin
        if (rnd < FS_MIN) begin
            fs_next = 16'(slm_pkg::FS_LEVEL_MIN);
        end else if (rnd > FS_MAX) begin
            fs_next = '0;
        end else begin
            fs_next = rnd[15:0];
        end
    end

    assign est_sum = 18'(fs_reg) + $signed({2'b00, cal_offset});

    always_comb begin
        if (est_sum < EST_LO) begin
            est_next = 15'(slm_pkg::EST_MIN);
        end else if (est_sum > EST_HI) begin
            est_next = 15'(slm_pkg::EST_MAX);
        end else begin
            est_next = est_sum[14:0];
        end
    end

    assign sdiff = $signed({4'b0000, est_reg, 8'h00}) - $signed({3'b000, s_reg});
    assign srnd  = (sprod_reg + 44'sd32768) >>> 16;

    assign s_rnd = {1'b0, s_reg} + 25'd128;
    assign s_q88 = s_rnd[24:8];

    always_comb begin
        if (s_q88 < 17'(slm_pkg::EST_MIN)) begin
            sm = 15'(slm_pkg::EST_MIN);
        end else if (s_q88 > 17'(slm_pkg::EST_MAX)) begin
            sm = 15'(slm_pkg::EST_MAX);
        end else begin
            sm = s_q88[14:0];
        end
    end

    assign lvl  = $signed({3'b000, sm});
    assign q_s  = $signed({3'b000, quiet_thresh});
    assign l_s  = $signed({3'b000, loud_thresh});
    assign mg_s = $signed({6'b000000, hyst_margin});

    always_comb begin
        case (cls_reg)
            slm_pkg::CLS_QUIET: begin
                cls_next = (lvl >= q_s + mg_s) ? slm_pkg::CLS_NORMAL : slm_pkg::CLS_QUIET;
            end
            slm_pkg::CLS_LOUD: begin
                cls_next = (lvl <= l_s - mg_s) ? slm_pkg::CLS_NORMAL : slm_pkg::CLS_LOUD;
            end
            default: begin
                if (lvl <= q_s - mg_s) begin
                    cls_next = slm_pkg::CLS_QUIET;
                end else if (lvl >= l_s + mg_s) begin
                    cls_next = slm_pkg::CLS_LOUD;
                end else begin
                    cls_next = slm_pkg::CLS_NORMAL;
                end
            end
        endcase
    end

    assign out_free = !m_valid_reg || m_ready;

    // datapath registers
    always_ff @(posedge aclk) begin
        if (fifo_pop) begin
            cnt_reg <= fifo_cnt;
            fs_reg  <= 16'(slm_pkg::FS_LEVEL_MIN);
        end
        if ((state_reg == ST_LOG_SUM) && log_done) begin
            lsum_reg <= log_res;
        end
        if ((state_reg == ST_LOG_CNT) && log_done) begin
            d_reg <= d_next;
        end
        if (state_reg == ST_SCALE) begin
            prod_reg <= P_W'(d_reg) * LOG_K;
        end
        if (state_reg == ST_ROUND) begin
            fs_reg <= fs_next;
        end
        if (state_reg == ST_EST) begin
            est_reg <= est_next;
        end
        if (state_reg == ST_SMUL) begin
            sprod_reg <= 44'(sdiff) * $signed({28'd0, smooth_weight});
        end
        if ((state_reg == ST_CLASS) && out_free) begin
            m_fs_reg  <= fs_reg;
            m_est_reg <= est_reg;
            m_sm_reg  <= sm;
            m_cls_reg <= cls_next;
        end
    end

    // sequencer and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            s_reg       <= slm_pkg::SMOOTH_RST;
            cls_reg     <= slm_pkg::CLS_NORMAL;
            m_valid_reg <= 1'b0;
        end else begin
            // load a new item, or drop the one taken by the receiver
            if ((state_reg == ST_CLASS) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (fifo_not_empty) begin
                        state_reg <= silent ? ST_EST : ST_LOG_SUM;
                    end
                end
                ST_LOG_SUM: begin
                    if (log_done) begin
                        state_reg <= ST_LOG_CNT;
                    end
                end
                ST_LOG_CNT: begin
                    if (log_done) begin
                        state_reg <= ST_SCALE;
                    end
                end
                ST_SCALE: state_reg <= ST_ROUND;
                ST_ROUND: state_reg <= ST_EST;
                ST_EST:   state_reg <= ST_SMUL;
                ST_SMUL:  state_reg <= ST_SADD;
                ST_SADD: begin
                    s_reg     <= s_reg + srnd[23:0];
                    state_reg <= ST_CLASS;
                end
                ST_CLASS: begin
                    // hold until the result register is free
                    if (out_free) begin
                        cls_reg   <= cls_next;
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_full_scale_level   = m_fs_reg;
    assign m_estimated_level    = m_est_reg;
    assign m_smoothed_level_out = m_sm_reg;
    assign m_level_class        = m_cls_reg;

endmodule

// ----- rtl/core/sound_level_meter_hysteresis.sv -----
// ----------------------------------------------------------------------------
// Sound level meter with hysteresis classification
// Takes one sample per cycle while s_ready is high; emits one level result per
// closed window. The front end squares and accumulates a sample every cycle
// while s_ready is high. Each closed window waits in a two-entry queue until
// the back end takes it; the back end finishes one window before it takes the
// next: two passes of an iterative log2 unit (shifts to the leading one within
// NORM_W = max(2*SAMPLE_BITS-1+COUNT_BITS, 32) bits, then 16 squaring steps),
// then six steps: scaling, rounding, calibration, two for smoothing and the
// classification. A silent window skips the log2 passes, scale and round.
// The last step holds while the result register is still waiting on m_ready.
// s_ready drops only while both queue entries hold windows.
// ----------------------------------------------------------------------------
module sound_level_meter_hysteresis #(
    parameter int SAMPLE_BITS = slm_pkg::SAMPLE_BITS_DEF,
    parameter int COUNT_BITS  = slm_pkg::COUNT_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [15:0]                  m_full_scale_level,
    output logic [14:0]                         m_estimated_level,
    output logic [14:0]                         m_smoothed_level_out,
    output logic [1:0]                          m_level_class,
    input  logic                                cfg_wr_en,
    input  logic [slm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [slm_pkg::CFG_W-1:0]           cfg_wdata
);

    localparam int SUM_W = 2 * (SAMPLE_BITS - 1) + 1 + COUNT_BITS;

    logic [15:0] window_length_reg;
    logic [15:0] cal_offset_reg;
    logic [15:0] smooth_weight_reg;
    logic [14:0] quiet_thresh_reg;
    logic [14:0] loud_thresh_reg;
    logic [11:0] hyst_margin_reg;

    logic                          fifo_full;
    logic                          fifo_push;
    logic                          fifo_pop;
    logic                          fifo_not_empty;
    logic [SUM_W-1:0]              push_sum;
    logic [COUNT_BITS-1:0]         push_cnt;
    logic [SUM_W+COUNT_BITS-1:0]   head_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= slm_pkg::WINDOW_LENGTH_RST;
            cal_offset_reg    <= slm_pkg::CAL_OFFSET_RST;
            smooth_weight_reg <= slm_pkg::SMOOTH_WEIGHT_RST;
            quiet_thresh_reg  <= slm_pkg::QUIET_THRESH_RST;
            loud_thresh_reg   <= slm_pkg::LOUD_THRESH_RST;
            hyst_margin_reg   <= slm_pkg::HYST_MARGIN_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                slm_pkg::REG_WINDOW_LENGTH: window_length_reg <= cfg_wdata;
                slm_pkg::REG_CAL_OFFSET:    cal_offset_reg    <= cfg_wdata;
                slm_pkg::REG_SMOOTH_WEIGHT: smooth_weight_reg <= cfg_wdata;
                slm_pkg::REG_QUIET_THRESH:  quiet_thresh_reg  <= cfg_wdata[14:0];
                slm_pkg::REG_LOUD_THRESH:   loud_thresh_reg   <= cfg_wdata[14:0];
                slm_pkg::REG_HYST_MARGIN:   hyst_margin_reg   <= cfg_wdata[11:0];
                default: ;
            endcase
        end
    end

    slm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_W       (SUM_W)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .window_length (window_length_reg),
        .fifo_full     (fifo_full),
        .fifo_push     (fifo_push),
        .push_sum      (push_sum),
        .push_cnt      (push_cnt)
    );

    slm_queue #(
        .DATA_W (SUM_W + COUNT_BITS)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (fifo_push),
        .push_data ({push_sum, push_cnt}),
        .pop       (fifo_pop),
        .full      (fifo_full),
        .not_empty (fifo_not_empty),
        .head_data (head_data)
    );

    slm_back #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS),
        .SUM_W       (SUM_W)
    ) u_back (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .fifo_not_empty       (fifo_not_empty),
        .fifo_sum             (head_data[SUM_W+COUNT_BITS-1:COUNT_BITS]),
        .fifo_cnt             (head_data[COUNT_BITS-1:0]),
        .fifo_pop             (fifo_pop),
        .cal_offset           (cal_offset_reg),
        .smooth_weight        (smooth_weight_reg),
        .quiet_thresh         (quiet_thresh_reg),
        .loud_thresh          (loud_thresh_reg),
        .hyst_margin          (hyst_margin_reg),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_full_scale_level   (m_full_scale_level),
        .m_estimated_level    (m_estimated_level),
        .m_smoothed_level_out (m_smoothed_level_out),
        .m_level_class        (m_level_class)
    );

endmodule

// ----- rtl/core/slm_checker.sv -----
// ----------------------------------------------------------------------------
// Sound level meter port checker
// Watches the result port of the top level over time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module slm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic signed [15:0] m_full_scale_level,
    input logic [14:0]        m_estimated_level,
    input logic [14:0]        m_smoothed_level_out,
    input logic [1:0]         m_level_class
);

    `SLM_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_valid)
    `SLM_ASSERT(a_class_code, aclk, aresetn, m_valid |-> (m_level_class != 2'd3))
    `SLM_ASSERT(a_levels_in_range, aclk, aresetn, m_valid |-> ((m_full_scale_level <= 16'sd0) && (m_full_scale_level >= -16'sd24576) && (m_estimated_level >= 15'd7680) && (m_estimated_level <= 15'd30720) && (m_smoothed_level_out >= 15'd7680) && (m_smoothed_level_out <= 15'd30720)))
    `SLM_ASSERT(a_stall_holds, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_level_class) && $stable(m_smoothed_level_out)))

endmodule

bind sound_level_meter_hysteresis slm_checker u_slm_checker (.*);
